// File: design/dsrh_pkg.sv
// package for the decimal string rs hash pipeline
// holds the stage payload types, the hash constants and the multiplier table
// no dependencies
package dsrh_pkg;

  localparam int unsigned TEXT_MAX   = 11;
  localparam int unsigned DIGITS     = 10;
  localparam int unsigned POS_W      = 4;

  localparam logic [31:0] RS_MULT_INIT = 32'd63689;
  localparam logic [31:0] RS_MULT_STEP = 32'd378551;
  localparam logic [31:0] RS_OUT_MASK  = 32'h7FFF_FFFF;
  // floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP10      = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT  = 35;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef logic [31:0] mult_tab_t [TEXT_MAX];

  // multiplier in effect at each text position
  function automatic mult_tab_t build_mult_tab();
    mult_tab_t   tab;
    logic [63:0] prod;
    tab[0] = RS_MULT_INIT;
    for (int i = 1; i < TEXT_MAX; i++) begin
      prod   = {32'b0, tab[i-1]} * {32'b0, RS_MULT_STEP};
      tab[i] = prod[31:0];
    end
    return tab;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

  // payload through the digit extraction stages
  typedef struct packed {
    logic                 neg;
    logic [31:0]          mag;
    logic [4*DIGITS-1:0]  digits;
  } digit_bus_t;

  // payload through the hash stages
  typedef struct packed {
    logic [31:0]          acc;
    logic [POS_W-1:0]     pos;
    logic                 started;
    logic [4*DIGITS-1:0]  digits;
  } hash_bus_t;

endpackage

// File: design/dsrh_digit_stage.sv
// one decimal digit extraction stage: divide by ten through a reciprocal
// multiply, shift the remainder digit into the digit word
// depends on dsrh_pkg
module dsrh_digit_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  dsrh_pkg::digit_bus_t bus_i,
  output logic                valid_o,
  output dsrh_pkg::digit_bus_t bus_o
);
  import dsrh_pkg::*;

  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;
  logic        valid_q;
  digit_bus_t  bus_d, bus_q;

  always_comb begin
    prod       = {32'b0, bus_i.mag} * {32'b0, RECIP10};
    quo        = {3'b0, prod[63:RECIP_SHIFT]};
    rem        = bus_i.mag - ((quo << 3) + (quo << 1));
    bus_d.neg    = bus_i.neg;
    bus_d.mag    = quo;
    bus_d.digits = {rem[3:0], bus_i.digits[4*DIGITS-1:4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign valid_o = valid_q;
  assign bus_o   = bus_q;

endmodule

// File: design/dsrh_hash_stage.sv
// one rs hash step: when the character is part of the text, multiply the
// accumulator by the multiplier for its position and add the character
// depends on dsrh_pkg
module dsrh_hash_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  dsrh_pkg::hash_bus_t bus_i,
  input  logic               take_i,
  input  logic [7:0]         char_i,
  input  logic               mark_i,
  output logic               valid_o,
  output dsrh_pkg::hash_bus_t bus_o
);
  import dsrh_pkg::*;

  logic [63:0] prod;
  logic        valid_q;
  hash_bus_t   bus_d, bus_q;

  always_comb begin
    prod  = {32'b0, bus_i.acc} * {32'b0, MULT_TAB[bus_i.pos]};
    bus_d = bus_i;
    bus_d.started = mark_i;
    if (take_i) begin
      bus_d.acc = prod[31:0] + {24'b0, char_i};
      bus_d.pos = POS_W'(bus_i.pos + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q <= bus_d;
    end
  end

  assign valid_o = valid_q;
  assign bus_o   = bus_q;

endmodule

// File: design/decimal_string_rs_hash.sv
// top level: rs hash of the signed decimal text of a 32-bit integer
// instantiates dsrh_digit_stage and dsrh_hash_stage, depends on dsrh_pkg
//
//   channel   direction  handshake            payload
//   request   in         valid_i / stall_o    value_i  (32 bits, signed)
//   result    out        valid_o / stall_i    hash_o   (31 bits)
//
// one request per cycle unless a held result stalls the pipeline, one result per
// request: one input stage, ten divide-by-ten stages (one decimal digit each,
// set by the 32x32 reciprocal multiply) and eleven hash stages (one text
// character each, set by the 32x32 accumulator multiply)
// reset clears only the stage valid bits; payload registers hold anything
// a stalled result freezes the whole pipeline, stall_o follows it the same cycle
module decimal_string_rs_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [30:0]        hash_o
);
  import dsrh_pkg::*;

  // global pipeline enable: everything moves unless the result is held
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // input stage: sign and magnitude
  logic        in_valid_q;
  digit_bus_t  in_bus_q;
  logic [31:0] raw;

  assign raw = $unsigned(value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_bus_q.neg    <= raw[31];
      in_bus_q.mag    <= raw[31] ? (~raw + 32'd1) : raw;
      in_bus_q.digits <= '0;
    end
  end

  // digit extraction: least significant digit first, each stage shifts its
  // digit in from the top so that after ten stages digit j sits in nibble j
  logic       dig_valid [DIGITS+1];
  digit_bus_t dig_bus   [DIGITS+1];

  assign dig_valid[0] = in_valid_q;
  assign dig_bus[0]   = in_bus_q;

  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    dsrh_digit_stage u_digit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dig_valid[k]),
      .bus_i   (dig_bus[k]),
      .valid_o (dig_valid[k+1]),
      .bus_o   (dig_bus[k+1])
    );
  end

  // hash stages: stage 0 takes the minus sign, stage k takes digit 10-k,
  // most significant first; leading zeros are skipped until the first
  // nonzero digit, and the units digit is always taken so zero gives "0"
  logic      h_valid [TEXT_MAX+1];
  hash_bus_t h_bus   [TEXT_MAX+1];

  assign h_valid[0]       = dig_valid[DIGITS];
  assign h_bus[0].acc     = '0;
  assign h_bus[0].pos     = '0;
  assign h_bus[0].started = 1'b0;
  assign h_bus[0].digits  = dig_bus[DIGITS].digits;

  // minus sign stage
  dsrh_hash_stage u_hash_sign (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_valid[0]),
    .bus_i   (h_bus[0]),
    .take_i  (dig_bus[DIGITS].neg),
    .char_i  (CHAR_MINUS),
    .mark_i  (1'b0),
    .valid_o (h_valid[1]),
    .bus_o   (h_bus[1])
  );

  for (genvar k = 1; k < TEXT_MAX; k++) begin : g_hash
    localparam int unsigned J = TEXT_MAX - 1 - k;
    logic [3:0] nib;
    logic       take;

    assign nib  = h_bus[k].digits[4*J +: 4];
    assign take = h_bus[k].started || (nib != 4'd0) || (J == 0);

    dsrh_hash_stage u_hash (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (h_valid[k]),
      .bus_i   (h_bus[k]),
      .take_i  (take),
      .char_i  (CHAR_ZERO | {4'b0, nib}),
      .mark_i  (take),
      .valid_o (h_valid[k+1]),
      .bus_o   (h_bus[k+1])
    );
  end

  // last hash stage doubles as the output register
  assign valid_o = h_valid[TEXT_MAX];
  assign hash_o  = h_bus[TEXT_MAX].acc[30:0];

endmodule

// File: design/dsrh_checker.sv
// port-level checks for decimal_string_rs_hash, bound to the top level
// depends on nothing but the top level's ports
module dsrh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               stall_o,
  input logic signed [31:0] value_i,
  input logic               valid_o,
  input logic               stall_i,
  input logic [30:0]        hash_o
);

  // the request side stalls exactly when a result is held
  a_stall_follows: assert property (@(posedge clk_i)
    stall_o == (valid_o && stall_i))
    else $error("stall_o does not track a held result");

  // no result is shown in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("result valid during reset");

  // a held result stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("held result dropped");

  // a held result keeps its value
  a_hold_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> $stable(hash_o))
    else $error("held result changed");

endmodule

bind decimal_string_rs_hash dsrh_checker u_dsrh_checker (.*);
